// ===== rtl/core/hcbp_pkg.sv =====
// Shared types and constants for the code bit packer.
// Used by the top, front and back modules under rtl/core; no dependencies of its own.
package hcbp_pkg;

  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int SYMBOL_COUNT_DEF = 256;
  localparam int CODE_W           = 32;
  localparam int LEN_W            = 6;
  localparam int SYM_FIELD_W      = 8;
  localparam int BYTE_W           = 8;
  localparam int CMD_DEPTH        = 4;
  localparam int OUT_DEPTH        = 4;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;
  // The remaining code has no function and is ignored.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]             op;
    logic [SYM_FIELD_W-1:0] symbol;
    logic [CODE_W-1:0]      code_bits;
    logic [LEN_W-1:0]       code_length;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
  } out_item_t;

  // Work handed from the lookup side to the packer.
  typedef struct packed {
    logic              is_flush;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } cmd_t;

endpackage

// ===== rtl/core/huffman_code_bit_packer_top.sv =====
// Code bit packer top level. The first byte of an encode or flush passes the front
// stage register, the command queue, the packer registers and the result queue.
// The front takes one transaction per cycle while full is low; the packer emits one
// byte per cycle while the result queue has room, and loads never reach the packer.
// Reset (rst, synchronous) clears queues, table valid bits and the accumulator.
module huffman_code_bit_packer_top #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
  parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  hcbp_pkg::in_item_t  cmd,
  output logic                empty,
  input  logic                pop,
  output hcbp_pkg::out_item_t result
);
  import hcbp_pkg::*;

  logic      cmd_push;
  logic      cmd_full;
  cmd_t      cmd_wr;
  cmd_t      cmd_rd;
  logic      cmd_empty;
  logic      cmd_pop;
  logic      byte_push;
  logic      byte_full;
  out_item_t byte_item;

  hcbp_front #(
    .MAX_CODE_LEN(MAX_CODE_LEN),
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .cmd      (cmd),
    .cmd_full (cmd_full),
    .cmd_push (cmd_push),
    .cmd_entry(cmd_wr)
  );

  hcbp_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk    (clk),
    .rst    (rst),
    .push   (cmd_push),
    .full   (cmd_full),
    .wr_data(cmd_wr),
    .empty  (cmd_empty),
    .pop    (cmd_pop),
    .rd_data(cmd_rd)
  );

  hcbp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_avail(!cmd_empty),
    .cmd_entry(cmd_rd),
    .cmd_pop  (cmd_pop),
    .byte_full(byte_full),
    .byte_push(byte_push),
    .byte_item(byte_item)
  );

  hcbp_fifo #(
    .WIDTH($bits(out_item_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk    (clk),
    .rst    (rst),
    .push   (byte_push),
    .full   (byte_full),
    .wr_data(byte_item),
    .empty  (empty),
    .pop    (pop),
    .rd_data(result)
  );

endmodule

// ===== rtl/core/hcbp_fifo.sv =====
// Small register queue with show-ahead read.
// Depends on nothing; used for the command queue and the result queue.
module hcbp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wr_data,
  output logic             empty,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH))
    else $error("queue occupancy above depth");

endmodule

// ===== rtl/core/hcbp_front.sv =====
// Front end: accepts transactions, keeps the code table and looks up codes.
// Depends on hcbp_pkg; feeds cmd_t entries to the command queue.
module hcbp_front #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
  parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  hcbp_pkg::in_item_t cmd,
  input  logic               cmd_full,
  output logic               cmd_push,
  output hcbp_pkg::cmd_t     cmd_entry
);
  import hcbp_pkg::*;

  localparam int SYM_W     = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int ENTRY_W   = LEN_W + CODE_W;

  logic [ENTRY_W-1:0]      code_mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] loaded;
  logic [ENTRY_W-1:0]      rd_entry;
  logic                    rd_loaded;
  logic                    s1_valid;
  logic                    s1_flush;
  logic [LEN_W-1:0]        s1_len;
  logic                    s1_useful;
  logic                    s1_stall;
  logic                    accept;
  logic                    in_range;
  logic                    is_load;
  logic                    is_encode;
  logic                    is_flush;
  logic [SYM_W-1:0]        addr;
  logic [LEN_W-1:0]        clen_sat;
  logic [CODE_W-1:0]       mask;

  assign accept    = push && !full;
  assign in_range  = {1'b0, cmd.symbol} < (SYM_FIELD_W+1)'(SYMBOL_COUNT);
  assign is_load   = (cmd.op == OP_LOAD);
  assign is_encode = (cmd.op == OP_ENCODE);
  assign is_flush  = (cmd.op == OP_FLUSH);
  assign addr      = cmd.symbol[SYM_W-1:0];
  assign clen_sat  = (cmd.code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT)
                                                            : cmd.code_length;
  assign mask      = (clen_sat >= LEN_W'(CODE_W)) ? '1
                                                  : ((CODE_W'(1) << clen_sat) - CODE_W'(1));

  // Table write and registered read; the read data holds while stage one stalls
  // because no transaction is accepted then.
  always_ff @(posedge clk) begin
    if (accept && is_load && in_range) begin
      code_mem[addr] <= {clen_sat, cmd.code_bits & mask};
    end
    if (accept && is_encode && in_range) begin
      rd_entry <= code_mem[addr];
    end
    if (!s1_stall) begin
      s1_flush <= is_flush;
    end
  end

  // An entry never loaded reads as length zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded    <= '0;
      rd_loaded <= 1'b0;
      s1_valid  <= 1'b0;
    end else begin
      if (accept && is_load && in_range) begin
        loaded[addr] <= 1'b1;
      end
      if (accept && is_encode && in_range) begin
        rd_loaded <= loaded[addr];
      end
      if (!s1_stall) begin
        s1_valid <= accept && ((is_encode && in_range) || is_flush);
      end
    end
  end

  assign s1_len    = rd_loaded ? rd_entry[ENTRY_W-1:CODE_W] : '0;
  assign s1_useful = s1_flush || (s1_len != '0);
  assign s1_stall  = s1_valid && s1_useful && cmd_full;
  assign full      = s1_stall;
  assign cmd_push  = s1_valid && s1_useful && !cmd_full;

  assign cmd_entry.is_flush = s1_flush;
  assign cmd_entry.len      = s1_len;
  assign cmd_entry.code     = rd_entry[CODE_W-1:0];

  a_no_empty_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> (cmd_entry.is_flush || (cmd_entry.len != '0)))
    else $error("zero-length encode reached the command queue");

endmodule

// ===== rtl/core/hcbp_back.sv =====
// Back end: packs code bits MSB first into bytes, one byte per cycle while the result queue has room.
// Depends on hcbp_pkg; reads the command queue and writes the result queue.
module hcbp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_avail,
  input  hcbp_pkg::cmd_t      cmd_entry,
  output logic                cmd_pop,
  input  logic                byte_full,
  output logic                byte_push,
  output hcbp_pkg::out_item_t byte_item
);
  import hcbp_pkg::*;

  logic              busy;
  logic              busy_next;
  logic              cur_flush;
  logic              cur_flush_next;
  logic [LEN_W-1:0]  cur_len;
  logic [LEN_W-1:0]  cur_len_next;
  logic [CODE_W-1:0] cur_code;
  logic [CODE_W-1:0] cur_code_next;
  logic [BYTE_W-1:0] pbits;
  logic [BYTE_W-1:0] pbits_next;
  logic [2:0]        pcount;
  logic [2:0]        pcount_next;
  logic [3:0]        need;
  logic [LEN_W-1:0]  rem;
  logic [CODE_W-1:0] shifted;
  logic [BYTE_W-1:0] merged;
  logic              emit;
  logic              fin;

  // cur_code is left-aligned, so bits past the code length are zero.
  assign need    = 4'd8 - {1'b0, pcount};
  assign rem     = cur_len - {2'b00, need};
  assign shifted = cur_code << need;
  assign merged  = pbits | (cur_code[CODE_W-1:CODE_W-BYTE_W] >> pcount);

  always_comb begin
    emit               = 1'b0;
    fin                = 1'b0;
    byte_item.out_byte = pbits;
    byte_item.last     = 1'b0;
    pbits_next         = pbits;
    pcount_next        = pcount;
    cur_len_next       = cur_len;
    cur_code_next      = cur_code;
    cur_flush_next     = cur_flush;
    if (busy) begin
      if (cur_flush) begin
        emit           = (pcount != 3'd0);
        byte_item.last = 1'b1;
        if (!emit || !byte_full) begin
          fin         = 1'b1;
          pbits_next  = '0;
          pcount_next = 3'd0;
        end
      end else if (cur_len >= {2'b00, need}) begin
        emit               = 1'b1;
        byte_item.out_byte = merged;
        byte_item.last     = (rem < LEN_W'(BYTE_W));
        if (!byte_full) begin
          cur_code_next = shifted;
          cur_len_next  = rem;
          if (byte_item.last) begin
            fin         = 1'b1;
            pbits_next  = shifted[CODE_W-1:CODE_W-BYTE_W];
            pcount_next = rem[2:0];
          end else begin
            pbits_next  = '0;
            pcount_next = 3'd0;
          end
        end
      end else begin
        // The rest of the code fits in the open byte.
        fin         = 1'b1;
        pbits_next  = merged;
        pcount_next = pcount + cur_len[2:0];
      end
    end
    cmd_pop   = cmd_avail && (!busy || fin);
    byte_push = emit && !byte_full;
    busy_next = cmd_pop ? 1'b1 : (fin ? 1'b0 : busy);
    if (cmd_pop) begin
      cur_flush_next = cmd_entry.is_flush;
      cur_len_next   = cmd_entry.len;
      cur_code_next  = cmd_entry.code << (LEN_W'(CODE_W) - cmd_entry.len);
    end
  end

  always_ff @(posedge clk) begin
    cur_flush <= cur_flush_next;
    cur_len   <= cur_len_next;
    cur_code  <= cur_code_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      pbits  <= '0;
      pcount <= 3'd0;
    end else begin
      busy   <= busy_next;
      pbits  <= pbits_next;
      pcount <= pcount_next;
    end
  end

  a_more_bytes: assert property (@(posedge clk) disable iff (rst)
    byte_push && !byte_item.last |=> busy)
    else $error("packer went idle before the final byte");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    busy && cur_flush && fin |=> (pcount == 3'd0) && (pbits == '0))
    else $error("flush left bits in the accumulator");

endmodule
